[hdl/gnm_pkg.sv]
package gnm_pkg;

	localparam int NUM_POS = 32;
	localparam int POS_W = 5;
	localparam int LEN_W = 6;
	localparam int ACT_W = NUM_POS + 1;

	localparam logic [7:0] CH_STAR     = 8'h2a;
	localparam logic [7:0] CH_QUEST    = 8'h3f;
	localparam logic [7:0] CH_LBRACKET = 8'h5b;
	localparam logic [7:0] CH_RBRACKET = 8'h5d;
	localparam logic [7:0] CH_BANG     = 8'h21;
	localparam logic [7:0] CH_CARET    = 8'h5e;
	localparam logic [7:0] CH_DASH     = 8'h2d;

	localparam logic [3:0] ROLE_DEAD  = 4'd0;
	localparam logic [3:0] ROLE_LIT   = 4'd1;
	localparam logic [3:0] ROLE_ANY   = 4'd2;
	localparam logic [3:0] ROLE_STAR  = 4'd3;
	localparam logic [3:0] ROLE_OPEN  = 4'd4;
	localparam logic [3:0] ROLE_NEG   = 4'd5;
	localparam logic [3:0] ROLE_ELEM  = 4'd6;
	localparam logic [3:0] ROLE_RANGE = 4'd7;
	localparam logic [3:0] ROLE_SKIP  = 4'd8;
	localparam logic [3:0] ROLE_CLOSE = 4'd9;

	localparam logic [2:0] REG_CHARS_A = 3'd0;
	localparam logic [2:0] REG_CHARS_B = 3'd1;
	localparam logic [2:0] REG_CHARS_C = 3'd2;
	localparam logic [2:0] REG_CHARS_D = 3'd3;
	localparam logic [2:0] REG_LENGTH  = 3'd4;

	typedef logic [3:0] role_t;
	typedef logic [7:0] char_t;

	typedef struct packed {
		logic act;
		logic neg;
		logic hit;
	} chain_t;

endpackage

[hdl/gnm_if.sv]
interface gnm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] name_byte;
	logic       last_byte;
	modport source (output valid, output name_byte, output last_byte, input ready);
	modport sink (input valid, input name_byte, input last_byte, output ready);
endinterface

interface gnm_out_if;
	logic valid;
	logic ready;
	logic matched;
	modport source (output valid, output matched, input ready);
	modport sink (input valid, input matched, output ready);
endinterface

[hdl/gnm_parser.sv]
module gnm_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  gnm_pkg::char_t              chars [gnm_pkg::NUM_POS],
	input  logic [gnm_pkg::LEN_W-1:0]   len_used,
	output gnm_pkg::role_t              roles [gnm_pkg::NUM_POS],
	output logic                        busy
);

	localparam logic [1:0] ST_TOP   = 2'd0;
	localparam logic [1:0] ST_FIRST = 2'd1;
	localparam logic [1:0] ST_LEAD  = 2'd2;
	localparam logic [1:0] ST_BODY  = 2'd3;

	logic [gnm_pkg::LEN_W-1:0] pos_q;
	logic [1:0]                st_q, st_d;
	logic [1:0]                skip_q, skip_d;
	gnm_pkg::role_t            roles_q [gnm_pkg::NUM_POS];
	gnm_pkg::role_t            role_d;
	logic [gnm_pkg::POS_W-1:0] pidx;
	gnm_pkg::char_t            ch, ch1, ch2;
	logic                      is_range;
	gnm_pkg::role_t            elem_role;
	logic [1:0]                elem_skip;

	assign pidx = pos_q[gnm_pkg::POS_W-1:0];
	assign busy = !pos_q[gnm_pkg::LEN_W-1];
	assign roles = roles_q;

	always_comb begin
		ch  = chars[pidx];
		ch1 = (pidx < gnm_pkg::POS_W'(gnm_pkg::NUM_POS - 1)) ? chars[pidx + 1'b1] : 8'h00;
		ch2 = (pidx < gnm_pkg::POS_W'(gnm_pkg::NUM_POS - 2)) ? chars[pidx + 2'd2] : 8'h00;
		is_range = (ch1 == gnm_pkg::CH_DASH) && (ch2 != gnm_pkg::CH_RBRACKET)
			&& (pidx < gnm_pkg::POS_W'(gnm_pkg::NUM_POS - 2));
		elem_role = is_range ? gnm_pkg::ROLE_RANGE : gnm_pkg::ROLE_ELEM;
		elem_skip = is_range ? 2'd2 : 2'd0;
		role_d = gnm_pkg::ROLE_DEAD;
		st_d = st_q;
		skip_d = skip_q;
		if (skip_q != 2'd0) begin
			role_d = gnm_pkg::ROLE_SKIP;
			skip_d = skip_q - 1'b1;
		end else begin
			unique case (st_q)
				ST_TOP: begin
					if (ch == gnm_pkg::CH_LBRACKET) begin
						role_d = gnm_pkg::ROLE_OPEN;
						st_d = ST_FIRST;
					end else if (ch == gnm_pkg::CH_STAR) begin
						role_d = gnm_pkg::ROLE_STAR;
					end else if (ch == gnm_pkg::CH_QUEST) begin
						role_d = gnm_pkg::ROLE_ANY;
					end else begin
						role_d = gnm_pkg::ROLE_LIT;
					end
				end
				ST_FIRST: begin
					if (ch == gnm_pkg::CH_BANG || ch == gnm_pkg::CH_CARET) begin
						role_d = gnm_pkg::ROLE_NEG;
						st_d = ST_LEAD;
					end else begin
						role_d = elem_role;
						skip_d = elem_skip;
						st_d = ST_BODY;
					end
				end
				ST_LEAD: begin
					role_d = elem_role;
					skip_d = elem_skip;
					st_d = ST_BODY;
				end
				ST_BODY: begin
					if (ch == gnm_pkg::CH_RBRACKET) begin
						role_d = gnm_pkg::ROLE_CLOSE;
						st_d = ST_TOP;
					end else begin
						role_d = elem_role;
						skip_d = elem_skip;
					end
				end
				default: role_d = gnm_pkg::ROLE_DEAD;
			endcase
		end
		if (pos_q >= len_used) begin
			role_d = gnm_pkg::ROLE_DEAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			st_q <= ST_TOP;
			skip_q <= 2'd0;
			for (int i = 0; i < gnm_pkg::NUM_POS; i++) begin
				roles_q[i] <= gnm_pkg::ROLE_DEAD;
			end
		end else if (start) begin
			pos_q <= '0;
			st_q <= ST_TOP;
			skip_q <= 2'd0;
		end else if (busy) begin
			roles_q[pidx] <= role_d;
			pos_q <= pos_q + 1'b1;
			st_q <= st_d;
			skip_q <= skip_d;
		end
	end

endmodule

[hdl/gnm_cell.sv]
module gnm_cell (
	input  gnm_pkg::role_t  role,
	input  gnm_pkg::char_t  ch,
	input  gnm_pkg::char_t  hi_ch,
	input  logic [7:0]      name_byte,
	input  logic            act,
	input  logic            star_in,
	input  gnm_pkg::chain_t chain_in,
	input  logic            next_bit,
	input  logic            fin_in,
	output logic            star_out,
	output gnm_pkg::chain_t chain_out,
	output logic            nx_self,
	output logic            nx_next,
	output logic            fin_bit,
	output logic            fin_out
);

	logic cur;
	logic is_star;

	assign cur = act | star_in;
	assign is_star = (role == gnm_pkg::ROLE_STAR);
	assign star_out = cur & is_star;
	assign nx_self = cur & is_star;
	assign fin_bit = next_bit | fin_in;
	assign fin_out = fin_bit & is_star;

	always_comb begin
		chain_out = '0;
		nx_next = 1'b0;
		unique case (role)
			gnm_pkg::ROLE_LIT:   nx_next = cur & (ch == name_byte);
			gnm_pkg::ROLE_ANY:   nx_next = cur;
			gnm_pkg::ROLE_OPEN:  chain_out.act = cur;
			gnm_pkg::ROLE_NEG: begin
				chain_out = chain_in;
				chain_out.neg = 1'b1;
			end
			gnm_pkg::ROLE_ELEM: begin
				chain_out = chain_in;
				chain_out.hit = chain_in.hit | (ch == name_byte);
			end
			gnm_pkg::ROLE_RANGE: begin
				chain_out = chain_in;
				chain_out.hit = chain_in.hit | (($signed(ch) <= $signed(name_byte))
					&& ($signed(name_byte) <= $signed(hi_ch)));
			end
			gnm_pkg::ROLE_SKIP:  chain_out = chain_in;
			gnm_pkg::ROLE_CLOSE: nx_next = chain_in.act & (chain_in.hit ^ chain_in.neg);
			default: begin
				chain_out = '0;
				nx_next = 1'b0;
			end
		endcase
	end

endmodule

[hdl/glob_name_matcher_top.sv]
// Glob matcher for one file-name component.
// Configure the pattern over the APB port: four 64-bit words of pattern
// characters at 0x00..0x18 (character 0 in the low byte of word 0) and the
// pattern length at 0x20. Writes complete in the access cycle; reads return
// the stored value.
// Stream the name in on in_ch, one byte per beat, with last_byte set on the
// final byte. Only that final beat produces a beat on out_ch, carrying
// matched, in the cycle after the byte is accepted. After reset, and after
// every configuration write, the pattern is parsed into the cell row one
// character per cycle; in_ch.ready stays low until all 32 positions are
// parsed. Reset loads the pattern "*" and starts a fresh name. A stalled
// out_ch holds its beat. A byte is taken every cycle while the parser is
// idle and out_ch is empty or is being drained.
module glob_name_matcher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	gnm_in_if.sink      in_ch,
	gnm_out_if.source   out_ch
);

	localparam int N = gnm_pkg::NUM_POS;

	logic [63:0]               pat_q [4];
	logic [gnm_pkg::LEN_W-1:0] len_q;
	logic [gnm_pkg::LEN_W-1:0] len_used;
	gnm_pkg::char_t            chars [N];
	gnm_pkg::role_t            roles [N];
	logic                      busy;
	logic                      wr_en;
	logic [2:0]                reg_idx;
	logic [gnm_pkg::ACT_W-1:0] act_q;
	logic [gnm_pkg::ACT_W-1:0] next_vec;
	logic [gnm_pkg::ACT_W-1:0] fin_vec;
	logic [N:0]                star_c;
	logic [N:0]                fin_c;
	gnm_pkg::chain_t           chain_c [N+1];
	logic [N-1:0]              nx_self;
	logic [N-1:0]              nx_next;
	logic                      in_acc;
	logic                      out_vld_q;
	logic                      matched_q;

	assign pready = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr_en = psel & penable & pwrite;
	assign len_used = (len_q > gnm_pkg::LEN_W'(N)) ? gnm_pkg::LEN_W'(N) : len_q;

	always_comb begin
		unique case (reg_idx)
			gnm_pkg::REG_CHARS_A: prdata = pat_q[0];
			gnm_pkg::REG_CHARS_B: prdata = pat_q[1];
			gnm_pkg::REG_CHARS_C: prdata = pat_q[2];
			gnm_pkg::REG_CHARS_D: prdata = pat_q[3];
			gnm_pkg::REG_LENGTH:  prdata = {58'd0, len_q};
			default:              prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q[0] <= 64'd42;
			pat_q[1] <= 64'd0;
			pat_q[2] <= 64'd0;
			pat_q[3] <= 64'd0;
			len_q <= gnm_pkg::LEN_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				gnm_pkg::REG_CHARS_A: pat_q[0] <= pwdata;
				gnm_pkg::REG_CHARS_B: pat_q[1] <= pwdata;
				gnm_pkg::REG_CHARS_C: pat_q[2] <= pwdata;
				gnm_pkg::REG_CHARS_D: pat_q[3] <= pwdata;
				gnm_pkg::REG_LENGTH:  len_q <= pwdata[gnm_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_chars
		assign chars[i] = pat_q[i / 8][(i % 8) * 8 +: 8];
	end

	gnm_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (wr_en),
		.chars    (chars),
		.len_used (len_used),
		.roles    (roles),
		.busy     (busy)
	);

	assign star_c[0] = 1'b0;
	assign fin_c[0] = 1'b0;
	assign chain_c[0] = '0;

	for (genvar p = 0; p < N; p++) begin : g_cell
		logic           next_bit;
		gnm_pkg::char_t hi_ch;
		if (p == 0) begin : g_n0
			assign next_bit = nx_self[p];
		end else begin : g_np
			assign next_bit = nx_self[p] | nx_next[p-1];
		end
		if (p + 2 < N) begin : g_hi
			assign hi_ch = chars[p+2];
		end else begin : g_nohi
			assign hi_ch = 8'h00;
		end
		assign next_vec[p] = next_bit;
		gnm_cell u_cell (
			.role      (roles[p]),
			.ch        (chars[p]),
			.hi_ch     (hi_ch),
			.name_byte (in_ch.name_byte),
			.act       (act_q[p]),
			.star_in   (star_c[p]),
			.chain_in  (chain_c[p]),
			.next_bit  (next_bit),
			.fin_in    (fin_c[p]),
			.star_out  (star_c[p+1]),
			.chain_out (chain_c[p+1]),
			.nx_self   (nx_self[p]),
			.nx_next   (nx_next[p]),
			.fin_bit   (fin_vec[p]),
			.fin_out   (fin_c[p+1])
		);
	end

	assign next_vec[N] = nx_next[N-1];
	assign fin_vec[N] = next_vec[N] | fin_c[N];

	assign in_ch.ready = !busy && (!out_vld_q || out_ch.ready);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_vld_q;
	assign out_ch.matched = matched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= gnm_pkg::ACT_W'(1);
			out_vld_q <= 1'b0;
		end else begin
			if (in_acc) begin
				act_q <= in_ch.last_byte ? gnm_pkg::ACT_W'(1) : next_vec;
			end
			if (in_acc && in_ch.last_byte) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_ch.last_byte) begin
			matched_q <= fin_vec[len_used];
		end
	end

endmodule

[dv/glob_name_matcher_top_tb.sv]
`timescale 1ns / 1ps

module glob_name_matcher_top_tb;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		bit         cfg;
		logic [2:0] idx;
		logic [63:0] val;
		logic [7:0] nbyte;
		bit         last;
		bit         typed;
		bit         verdict;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	gnm_in_if  in_ch();
	gnm_out_if out_ch();

	glob_name_matcher_top dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	logic [63:0]               pat_word [4];
	logic [gnm_pkg::LEN_W-1:0] pat_len;
	logic [gnm_pkg::ACT_W-1:0] live_pos;
	bit                        verdict_q[$];
	int                        mismatches = 0;
	int                        cycles = 0;
	int                        snd_idle_pct = 0;
	int                        rcv_stall_pct = 0;
	int                        hold_left = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.name_byte = '0;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic int pat_char(int i);
		logic [7:0] b;
		b = pat_word[(i >> 3) & 3][(i & 7) * 8 +: 8];
		return int'($signed(b));
	endfunction

	function automatic int used_len();
		return (pat_len > gnm_pkg::NUM_POS) ? gnm_pkg::NUM_POS : int'(pat_len);
	endfunction

	function automatic int class_close(int first, int len);
		int i;
		i = first;
		if (i >= len)
			return -1;
		if (pat_char(i) == int'(gnm_pkg::CH_BANG) || pat_char(i) == int'(gnm_pkg::CH_CARET))
			i++;
		if (i < len && pat_char(i) == int'(gnm_pkg::CH_RBRACKET))
			i++;
		while (i < len && pat_char(i) != int'(gnm_pkg::CH_RBRACKET))
			i++;
		return (i < len) ? i : -1;
	endfunction

	function automatic bit class_match(int first, int stop, int c);
		bit neg;
		bit hit;
		int i;
		int lo;
		neg = 1'b0;
		hit = 1'b0;
		i = first;
		if (i < stop && (pat_char(i) == int'(gnm_pkg::CH_BANG)
			|| pat_char(i) == int'(gnm_pkg::CH_CARET))) begin
			neg = 1'b1;
			i++;
		end
		while (i < stop) begin
			lo = pat_char(i);
			i++;
			if (i < stop && i + 1 < stop && pat_char(i) == int'(gnm_pkg::CH_DASH)) begin
				if (c >= lo && c <= pat_char(i + 1))
					hit = 1'b1;
				i += 2;
			end else if (c == lo) begin
				hit = 1'b1;
			end
		end
		return neg ? !hit : hit;
	endfunction

	function automatic logic [gnm_pkg::ACT_W-1:0] star_extend(
		logic [gnm_pkg::ACT_W-1:0] s, int len);
		for (int p = 0; p < len; p++)
			if (s[p] && pat_char(p) == int'(gnm_pkg::CH_STAR))
				s[p + 1] = 1'b1;
		return s;
	endfunction

	// advance the live pattern positions by one name byte; returns 1 on a verdict
	function automatic bit match_byte(logic [7:0] nb, bit last, output bit hit);
		int len;
		int c;
		int tok;
		int e;
		logic [gnm_pkg::ACT_W-1:0] cur;
		logic [gnm_pkg::ACT_W-1:0] nxt;
		len = used_len();
		c = int'($signed(nb));
		cur = star_extend(live_pos, len);
		nxt = '0;
		hit = 1'b0;
		for (int p = 0; p < len; p++) begin
			if (cur[p]) begin
				tok = pat_char(p);
				if (tok == int'(gnm_pkg::CH_STAR)) begin
					nxt[p] = 1'b1;
				end else if (tok == int'(gnm_pkg::CH_QUEST)) begin
					nxt[p + 1] = 1'b1;
				end else if (tok == int'(gnm_pkg::CH_LBRACKET)) begin
					e = class_close(p + 1, len);
					if (e >= 0 && class_match(p + 1, e, c))
						nxt[e + 1] = 1'b1;
				end else if (tok == c) begin
					nxt[p + 1] = 1'b1;
				end
			end
		end
		if (last) begin
			nxt = star_extend(nxt, len);
			hit = nxt[len];
			live_pos = 1;
			return 1'b1;
		end
		live_pos = nxt;
		return 1'b0;
	endfunction

	task automatic reg_write(logic [2:0] idx, logic [63:0] val);
		wait (verdict_q.size() == 0);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx < gnm_pkg::REG_LENGTH)
			pat_word[idx] = val;
		else if (idx == gnm_pkg::REG_LENGTH)
			pat_len = val[gnm_pkg::LEN_W-1:0];
	endtask

	task automatic send_byte(logic [7:0] nb, bit last, bit typed, bit verdict);
		bit hit;
		in_ch.valid <= 1'b1;
		in_ch.name_byte <= nb;
		in_ch.last_byte <= last;
		do @(posedge clk); while (!in_ch.ready);
		if (match_byte(nb, last, hit))
			verdict_q.push_back(typed ? verdict : hit);
		if ($urandom_range(0, 99) < snd_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		bit want;
		if (out_ch.valid && out_ch.ready) begin
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected verdict beat: matched=%0b", out_ch.matched);
			end else begin
				want = verdict_q.pop_front();
				if (out_ch.matched !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("matched mismatch: expected %0b, got %0b", want,
							out_ch.matched);
				end
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
		end
	end

	function automatic logic [7:0] rand_pat_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return gnm_pkg::CH_STAR;
		if (r < 30) return gnm_pkg::CH_QUEST;
		if (r < 42) return gnm_pkg::CH_LBRACKET;
		if (r < 52) return gnm_pkg::CH_RBRACKET;
		if (r < 57) return gnm_pkg::CH_BANG;
		if (r < 62) return gnm_pkg::CH_CARET;
		if (r < 70) return gnm_pkg::CH_DASH;
		if (r < 95) return 8'h61 + 8'($urandom_range(0, 2));
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] rand_name_char(bit noisy);
		int r;
		r = $urandom_range(0, 99);
		if (noisy || r < 8) return 8'($urandom);
		if (r < 80) return 8'h61 + 8'($urandom_range(0, 2));
		if (r < 90) return gnm_pkg::CH_DASH;
		return gnm_pkg::CH_RBRACKET;
	endfunction

	stim_row_t dir_rows[] = '{
		'{0, 0, 0, 8'h61, 1, 1, 1},
		'{0, 0, 0, 8'h00, 1, 1, 1},
		'{0, 0, 0, 8'hff, 0, 0, 0},
		'{0, 0, 0, 8'h80, 1, 1, 1},
		'{1, gnm_pkg::REG_LENGTH, 0, 0, 0, 0, 0},
		'{0, 0, 0, 8'h61, 1, 1, 0},
		'{1, gnm_pkg::REG_CHARS_A, 64'h5d642d62215b3f61, 0, 0, 0, 0},
		'{1, gnm_pkg::REG_CHARS_B, 64'h2a2a2a2a5d2d5d5b, 0, 0, 0, 0},
		'{1, gnm_pkg::REG_LENGTH, 12, 0, 0, 0, 0},
		'{0, 0, 0, 8'h61, 0, 0, 0},
		'{0, 0, 0, 8'h78, 0, 0, 0},
		'{0, 0, 0, 8'h65, 0, 0, 0},
		'{0, 0, 0, 8'h2d, 1, 0, 0},
		'{0, 0, 0, 8'h61, 0, 0, 0},
		'{0, 0, 0, 8'h78, 0, 0, 0},
		'{0, 0, 0, 8'h63, 0, 0, 0},
		'{0, 0, 0, 8'h5d, 1, 0, 0},
		'{1, gnm_pkg::REG_LENGTH, 9, 0, 0, 0, 0},
		'{0, 0, 0, 8'h61, 0, 0, 0},
		'{0, 0, 0, 8'h78, 0, 0, 0},
		'{0, 0, 0, 8'h65, 0, 0, 0},
		'{0, 0, 0, 8'h5d, 1, 1, 0},
		'{1, gnm_pkg::REG_CHARS_C, 64'h5dff2d805b2a2a2a, 0, 0, 0, 0},
		'{1, gnm_pkg::REG_CHARS_D, 64'hffffffffffffffff, 0, 0, 0, 0},
		'{1, gnm_pkg::REG_LENGTH, 63, 0, 0, 0, 0}
	};

	initial begin
		int nlen;
		bit noisy;
		logic [63:0] w;
		pat_word = '{64'd42, 64'd0, 64'd0, 64'd0};
		pat_len = 1;
		live_pos = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg) begin
				in_ch.valid <= 1'b0;
				reg_write(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				send_byte(dir_rows[i].nbyte, dir_rows[i].last, dir_rows[i].typed,
					dir_rows[i].verdict);
			end
		end
		send_byte(8'h7f, 1'b1, 1'b0, 1'b0);

		for (int ph = 0; ph < 8; ph++) begin
			in_ch.valid <= 1'b0;
			case (ph % 4)
				0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin snd_idle_pct = 61; rcv_stall_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct = 61; end
				default: begin snd_idle_pct = 33; rcv_stall_pct = 33; end
			endcase
			for (int k = 0; k < 4; k++) begin
				if (ph == 7) begin
					w = (k == 0) ? '1 : '0;
				end else begin
					for (int j = 0; j < 8; j++)
						w[j * 8 +: 8] = rand_pat_char();
				end
				reg_write(3'(k), w);
			end
			case (ph)
				0: reg_write(gnm_pkg::REG_LENGTH, 32);
				1: reg_write(gnm_pkg::REG_LENGTH, 1);
				7: reg_write(gnm_pkg::REG_LENGTH, 8);
				default: reg_write(gnm_pkg::REG_LENGTH, 64'($urandom_range(2, 12)));
			endcase
			if (ph == 0)
				hold_left = HOLD_CYCLES;
			for (int n = 0; n < 125; ) begin
				nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
				noisy = ($urandom_range(0, 9) == 0);
				for (int b = 0; b < nlen; b++) begin
					send_byte(rand_name_char(noisy), b == nlen - 1, 1'b0, 1'b0);
					n++;
				end
				if (ph == 3 && n > 60 && n <= 60 + nlen) begin
					in_ch.valid <= 1'b0;
					wait (verdict_q.size() == 0);
					@(posedge clk);
				end
			end
		end
		in_ch.valid <= 1'b0;

		wait (verdict_q.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[glob_name_matcher_top.f]
hdl/gnm_pkg.sv
hdl/gnm_if.sv
hdl/gnm_parser.sv
hdl/gnm_cell.sv
hdl/glob_name_matcher_top.sv
dv/glob_name_matcher_top_tb.sv
